@@ design/ship_rrip_way_replacement_top_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the replacement state RTL.
// Every macro expects signals named clk and arst_n in the calling module.
// ----------------------------------------------------------------------------
`ifndef SHIP_RRIP_WAY_REPLACEMENT_TOP_ASSERT_SVH
`define SHIP_RRIP_WAY_REPLACEMENT_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SHIPRRIP_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SHIPRRIP_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/shiprrip_pkg.sv @@
// ----------------------------------------------------------------------------
// shiprrip_pkg
// Constants, request codes and the structures passed between the sequencer,
// the shared scan unit and the per-way state store.
// ----------------------------------------------------------------------------
package shiprrip_pkg;

	localparam int SET_WAYS  = 16;
	localparam int STAMP_W   = 32;
	localparam int IDX_W     = (SET_WAYS > 1) ? $clog2(SET_WAYS) : 1;
	localparam int PTR_W     = IDX_W + 1;
	localparam int RRPV_W    = 4;
	localparam int AGE_W     = 5;
	localparam int COUNT_W   = 5;
	localparam int WAY_W     = 4;
	localparam int CFG_W     = 5;
	localparam int CFG_IDX_W = 2;

	localparam logic [AGE_W-1:0]   AGE_NONE   = 5'd16;
	localparam logic [RRPV_W-1:0]  RRPV_EMPTY = 4'hF;
	localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
	localparam logic [PTR_W-1:0]   WAYS_PTR   = PTR_W'(SET_WAYS);

	typedef enum logic [2:0] {
		FUNC_AGE    = 3'd0,
		FUNC_HIT    = 3'd1,
		FUNC_FILL   = 3'd2,
		FUNC_EVICT  = 3'd3,
		FUNC_VMAIN  = 3'd4,
		FUNC_VRES   = 3'd5,
		FUNC_READ   = 3'd6,
		FUNC_COUNT  = 3'd7
	} func_t;

	localparam logic [CFG_IDX_W-1:0] CFG_MAX_RRPV    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INSERT_BASE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RESERVED    = 2'd2;

	typedef struct packed {
		logic [RRPV_W-1:0] max_rrpv;
		logic [4:0]        insert_base;
	} cfg_t;

	typedef struct packed {
		func_t      op;
		logic       from_llc;
		logic [2:0] sig_hist;
		logic [3:0] threshold;
	} req_t;

	typedef struct packed {
		logic             clear;
		logic             step;
		logic [IDX_W-1:0] idx;
	} scan_ctrl_t;

	typedef struct packed {
		logic [RRPV_W-1:0]  rrpv;
		logic               empty;
		logic [STAMP_W-1:0] stamp;
	} entry_t;

	typedef struct packed {
		logic             we;
		logic             stamp_we;
		logic [IDX_W-1:0] idx;
		entry_t           data;
	} way_wr_t;

	typedef struct packed {
		logic               found;
		logic [IDX_W-1:0]   best_idx;
		logic [RRPV_W-1:0]  best_rrpv;
		logic [RRPV_W-1:0]  counter_value;
		logic [COUNT_W-1:0] count;
	} scan_res_t;

	function automatic logic [IDX_W-1:0] way_to_idx(input logic [WAY_W-1:0] w);
		logic [IDX_W+WAY_W-1:0] t;
		t = {{IDX_W{1'b0}}, w};
		return t[IDX_W-1:0];
	endfunction

	function automatic logic way_in_range(input logic [WAY_W-1:0] w);
		logic [IDX_W+WAY_W-1:0] t;
		t = {{IDX_W{1'b0}}, w};
		return t < (IDX_W + WAY_W)'(SET_WAYS);
	endfunction

	function automatic logic [WAY_W-1:0] idx_to_way(input logic [IDX_W-1:0] i);
		logic [IDX_W+WAY_W-1:0] t;
		t = {{WAY_W{1'b0}}, i};
		return t[WAY_W-1:0];
	endfunction

endpackage

@@ design/shiprrip_ways.sv @@
// ----------------------------------------------------------------------------
// shiprrip_ways
// Per-way store of re-reference counters, empty marks and fill stamps, with
// one read address and one write port.
// ----------------------------------------------------------------------------
module shiprrip_ways (
	input  logic                                clk,
	input  logic                                arst_n,
	input  shiprrip_pkg::way_wr_t               wr,
	input  logic [shiprrip_pkg::IDX_W-1:0]      rd_idx,
	output shiprrip_pkg::entry_t                rd
);

	logic [shiprrip_pkg::RRPV_W-1:0]  rrpv_q  [shiprrip_pkg::SET_WAYS];
	logic                             empty_q [shiprrip_pkg::SET_WAYS];
	logic [shiprrip_pkg::STAMP_W-1:0] stamp_q [shiprrip_pkg::SET_WAYS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < shiprrip_pkg::SET_WAYS; i++) begin
				rrpv_q[i]  <= '0;
				empty_q[i] <= 1'b1;
				stamp_q[i] <= '1;
			end
		end else begin
			if (wr.we) begin
				rrpv_q[wr.idx]  <= wr.data.rrpv;
				empty_q[wr.idx] <= wr.data.empty;
			end
			if (wr.stamp_we) begin
				stamp_q[wr.idx] <= wr.data.stamp;
			end
		end
	end

	assign rd.rrpv  = rrpv_q[rd_idx];
	assign rd.empty = empty_q[rd_idx];
	assign rd.stamp = stamp_q[rd_idx];

endmodule

@@ design/shiprrip_scan.sv @@
// ----------------------------------------------------------------------------
// shiprrip_scan
// Shared per-way unit: computes the write-back of one way for aging, hit,
// fill and evict, and accumulates the victim search, read and count results.
// ----------------------------------------------------------------------------
module shiprrip_scan (
	input  logic                                clk,
	input  logic                                arst_n,
	input  shiprrip_pkg::scan_ctrl_t            ctrl,
	input  shiprrip_pkg::req_t                  req,
	input  shiprrip_pkg::cfg_t                  cfg,
	input  logic [shiprrip_pkg::AGE_W-1:0]      pending_age,
	input  logic [shiprrip_pkg::STAMP_W-1:0]    access_clock,
	input  shiprrip_pkg::entry_t                entry,
	output shiprrip_pkg::way_wr_t               wr,
	output shiprrip_pkg::scan_res_t             res
);

	logic                             found_q;
	logic [shiprrip_pkg::IDX_W-1:0]   best_idx_q;
	logic [shiprrip_pkg::RRPV_W-1:0]  best_rrpv_q;
	logic [shiprrip_pkg::STAMP_W-1:0] best_stamp_q;
	logic [shiprrip_pkg::RRPV_W-1:0]  cval_q;
	logic [shiprrip_pkg::COUNT_W-1:0] count_q;

	logic       candidate;
	logic       better;
	logic [4:0] age_sum;
	logic [3:0] aged;
	logic [4:0] sub;
	logic [4:0] fill_raw;
	logic [3:0] fill_v;

	assign candidate = !entry.empty && (entry.rrpv <= cfg.max_rrpv);
	assign better    = !found_q || (entry.rrpv > best_rrpv_q) ||
		((entry.rrpv == best_rrpv_q) && (entry.stamp < best_stamp_q));

	// Saturating age, which also pulls counters above the limit back down.
	assign age_sum = {1'b0, entry.rrpv} + pending_age;
	assign aged    = (age_sum <= {1'b0, cfg.max_rrpv}) ? age_sum[3:0] : cfg.max_rrpv;

	assign sub      = (req.sig_hist != 3'd0) ? 5'd2 : 5'd1;
	assign fill_raw = (req.from_llc || (cfg.insert_base < sub)) ? 5'd0
		: (cfg.insert_base - sub);
	assign fill_v   = (fill_raw > 5'd15) ? 4'hF : fill_raw[3:0];

	always_comb begin
		wr          = '0;
		wr.idx      = ctrl.idx;
		wr.data     = entry;
		case (req.op)
			shiprrip_pkg::FUNC_AGE: begin
				wr.we        = ctrl.step && !entry.empty;
				wr.data.rrpv = aged;
			end
			shiprrip_pkg::FUNC_HIT: begin
				wr.we         = ctrl.step;
				wr.data.rrpv  = '0;
				wr.data.empty = 1'b0;
			end
			shiprrip_pkg::FUNC_FILL: begin
				wr.we         = ctrl.step;
				wr.stamp_we   = ctrl.step;
				wr.data.rrpv  = fill_v;
				wr.data.empty = 1'b0;
				wr.data.stamp = access_clock;
			end
			shiprrip_pkg::FUNC_EVICT: begin
				wr.we         = ctrl.step;
				wr.stamp_we   = ctrl.step;
				wr.data.rrpv  = '0;
				wr.data.empty = 1'b1;
				wr.data.stamp = '1;
			end
			default: begin
				wr.we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			count_q <= '0;
		end else if (ctrl.clear) begin
			found_q <= 1'b0;
			count_q <= '0;
		end else if (ctrl.step) begin
			case (req.op)
				shiprrip_pkg::FUNC_VMAIN, shiprrip_pkg::FUNC_VRES: begin
					if (candidate) begin
						found_q <= 1'b1;
					end
				end
				shiprrip_pkg::FUNC_COUNT: begin
					if ((entry.empty || (entry.rrpv > req.threshold)) &&
						(count_q != shiprrip_pkg::COUNT_MAX)) begin
						count_q <= count_q + 1'b1;
					end
				end
				default: begin
					count_q <= count_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			best_idx_q   <= '0;
			best_rrpv_q  <= '0;
			best_stamp_q <= '0;
			cval_q       <= shiprrip_pkg::RRPV_EMPTY;
		end else if (ctrl.step) begin
			case (req.op)
				shiprrip_pkg::FUNC_VMAIN, shiprrip_pkg::FUNC_VRES: begin
					if (candidate && better) begin
						best_idx_q   <= ctrl.idx;
						best_rrpv_q  <= entry.rrpv;
						best_stamp_q <= entry.stamp;
					end
				end
				shiprrip_pkg::FUNC_READ: begin
					if (!entry.empty) begin
						cval_q <= entry.rrpv;
					end
				end
				default: begin
					cval_q <= cval_q;
				end
			endcase
		end
	end

	assign res.found         = found_q;
	assign res.best_idx      = best_idx_q;
	assign res.best_rrpv     = best_rrpv_q;
	assign res.counter_value = cval_q;
	assign res.count         = count_q;

endmodule

@@ design/ship_rrip_way_replacement_top.sv @@
// A request on a single way (hit, fill, evict, read) walks at most that way;
// a request that walks the set (aging, count, victim search) steps through
// every way in its range. After the walk the sequencer registers the result.
// The sequencer, with its single per-way scan unit, holds one request at a
// time; a new request may be taken in the cycle the result shows.
// Reset: asynchronous, active low; all ways empty, no age pending, clock zero.
// ----------------------------------------------------------------------------
// ship_rrip_way_replacement_top
// Re-reference prediction replacement state for one cache set with lazy aging,
// driven by a small sequencer around a shared per-way scan unit. Results are
// never held off by the receiver, so the walk alone sets the timing.
// ----------------------------------------------------------------------------
`include "ship_rrip_way_replacement_top_assert.svh"

module ship_rrip_way_replacement_top (
	input  logic                                      clk,
	input  logic                                      arst_n,
	// Configuration write port.
	input  logic                                      cfg_we,
	input  logic [shiprrip_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [shiprrip_pkg::CFG_W-1:0]            cfg_wdata,
	// Request side.
	input  logic                                      start,
	output logic                                      busy,
	input  logic [2:0]                                func,
	input  logic [shiprrip_pkg::WAY_W-1:0]            way,
	input  logic                                      from_llc,
	input  logic [2:0]                                sig_hist,
	input  logic [3:0]                                threshold,
	// Result side: valid for exactly one cycle while done is high.
	output logic                                      done,
	output logic [3:0]                                victim_way,
	output logic [3:0]                                counter_value,
	output logic [4:0]                                count_above,
	output logic                                      error
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SCAN = 2'b10
	} state_t;

	localparam int RW = shiprrip_pkg::PTR_W + 4;

	state_t state_q;

	// Configuration registers.
	logic [3:0] max_rrpv_q;
	logic [4:0] insert_base_q;
	logic [3:0] reserved_q;

	// Set-wide state: age still owed to the counters and the access clock.
	logic [shiprrip_pkg::AGE_W-1:0]   pending_age_q;
	logic [shiprrip_pkg::STAMP_W-1:0] access_clock_q;

	// The request being worked on and the range of ways it walks.
	shiprrip_pkg::req_t             req_q;
	logic                           err_q;
	logic [shiprrip_pkg::PTR_W-1:0] ptr_q;
	logic [shiprrip_pkg::PTR_W-1:0] end_q;
	logic [shiprrip_pkg::PTR_W-1:0] lo_q;

	// Result registers.
	logic       done_q;
	logic [3:0] victim_q;
	logic [3:0] cval_q;
	logic [4:0] count_q;
	logic       error_q;

	logic                           accept;
	shiprrip_pkg::func_t            func_in;
	logic [RW-1:0]                  r_wide;
	logic [shiprrip_pkg::PTR_W-1:0] r_cnt;
	logic [shiprrip_pkg::PTR_W-1:0] way_ptr;
	logic                           way_ok;
	logic [shiprrip_pkg::PTR_W-1:0] lo_d;
	logic [shiprrip_pkg::PTR_W-1:0] hi_d;
	logic                           err_d;
	logic                           finish;
	logic [3:0]                     gap;

	shiprrip_pkg::scan_ctrl_t ctrl;
	shiprrip_pkg::cfg_t       cfg;
	shiprrip_pkg::entry_t     entry;
	shiprrip_pkg::way_wr_t    wr;
	shiprrip_pkg::scan_res_t  res;

	assign busy    = (state_q != ST_IDLE);
	assign accept  = start && !busy;
	assign func_in = shiprrip_pkg::func_t'(func);

	// Configuration writes; an index beyond the register list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_rrpv_q    <= 4'd3;
			insert_base_q <= 5'd4;
			reserved_q    <= 4'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				shiprrip_pkg::CFG_MAX_RRPV:    max_rrpv_q    <= cfg_wdata[3:0];
				shiprrip_pkg::CFG_INSERT_BASE: insert_base_q <= cfg_wdata;
				shiprrip_pkg::CFG_RESERVED:    reserved_q    <= cfg_wdata[3:0];
				default: begin
					max_rrpv_q <= max_rrpv_q;
				end
			endcase
		end
	end

	// The reserved partition cannot be larger than the set.
	assign r_wide = RW'(reserved_q);
	assign r_cnt  = (r_wide > RW'(shiprrip_pkg::SET_WAYS)) ? shiprrip_pkg::WAYS_PTR
		: r_wide[shiprrip_pkg::PTR_W-1:0];

	assign way_ok  = shiprrip_pkg::way_in_range(way);
	assign way_ptr = shiprrip_pkg::PTR_W'(shiprrip_pkg::way_to_idx(way));

	// Every request is a walk over a range of ways. Single-way requests walk
	// one way, or none when the way lies outside the set; aging walks nothing
	// when the owed age is not below the counter limit.
	always_comb begin
		lo_d  = '0;
		hi_d  = '0;
		err_d = 1'b0;
		case (func_in)
			shiprrip_pkg::FUNC_AGE: begin
				if (pending_age_q < {1'b0, max_rrpv_q}) begin
					hi_d = shiprrip_pkg::WAYS_PTR;
				end
			end
			shiprrip_pkg::FUNC_HIT, shiprrip_pkg::FUNC_FILL,
			shiprrip_pkg::FUNC_EVICT, shiprrip_pkg::FUNC_READ: begin
				if (way_ok) begin
					lo_d = way_ptr;
					hi_d = way_ptr + 1'b1;
				end
			end
			shiprrip_pkg::FUNC_VMAIN: begin
				hi_d = shiprrip_pkg::WAYS_PTR - r_cnt;
			end
			shiprrip_pkg::FUNC_VRES: begin
				if (r_cnt == '0) begin
					err_d = 1'b1;
				end else begin
					lo_d = shiprrip_pkg::WAYS_PTR - r_cnt;
					hi_d = shiprrip_pkg::WAYS_PTR;
				end
			end
			default: begin
				hi_d = shiprrip_pkg::WAYS_PTR;
			end
		endcase
	end

	assign ctrl.clear = accept;
	assign ctrl.step  = (state_q == ST_SCAN) && (ptr_q < end_q);
	assign ctrl.idx   = ptr_q[shiprrip_pkg::IDX_W-1:0];
	assign finish     = (state_q == ST_SCAN) && (ptr_q >= end_q);

	assign cfg.max_rrpv    = max_rrpv_q;
	assign cfg.insert_base = insert_base_q;

	// The chosen counter never exceeds the limit, so the gap is never negative.
	assign gap = max_rrpv_q - res.best_rrpv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			pending_age_q  <= shiprrip_pkg::AGE_NONE;
			access_clock_q <= '0;
			done_q         <= 1'b0;
			ptr_q          <= '0;
			end_q          <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_SCAN;
						ptr_q   <= lo_d;
						end_q   <= hi_d;
					end
				end
				ST_SCAN: begin
					if (ctrl.step) begin
						ptr_q <= ptr_q + 1'b1;
					end else begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
						case (req_q.op)
							shiprrip_pkg::FUNC_AGE: begin
								pending_age_q  <= shiprrip_pkg::AGE_NONE;
								access_clock_q <= access_clock_q + 1'b1;
							end
							shiprrip_pkg::FUNC_VMAIN, shiprrip_pkg::FUNC_VRES: begin
								if (res.found && ({1'b0, gap} < pending_age_q)) begin
									pending_age_q <= {1'b0, gap};
								end
							end
							default: begin
								pending_age_q <= pending_age_q;
							end
						endcase
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Request fields and result values carry no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q.op        <= func_in;
			req_q.from_llc  <= from_llc;
			req_q.sig_hist  <= sig_hist;
			req_q.threshold <= threshold;
			err_q           <= err_d;
			lo_q            <= lo_d;
		end
		if (finish) begin
			victim_q <= 4'd0;
			cval_q   <= 4'd0;
			count_q  <= 5'd0;
			error_q  <= err_q;
			case (req_q.op)
				shiprrip_pkg::FUNC_VMAIN, shiprrip_pkg::FUNC_VRES: begin
					// With no candidate the first way of the range is returned.
					victim_q <= res.found ? shiprrip_pkg::idx_to_way(res.best_idx)
						: shiprrip_pkg::idx_to_way(lo_q[shiprrip_pkg::IDX_W-1:0]);
				end
				shiprrip_pkg::FUNC_READ: begin
					cval_q <= res.counter_value;
				end
				shiprrip_pkg::FUNC_COUNT: begin
					count_q <= res.count;
				end
				default: begin
					victim_q <= 4'd0;
				end
			endcase
		end
	end

	shiprrip_ways u_ways (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.rd_idx (ctrl.idx),
		.rd     (entry)
	);

	shiprrip_scan u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.req          (req_q),
		.cfg          (cfg),
		.pending_age  (pending_age_q),
		.access_clock (access_clock_q),
		.entry        (entry),
		.wr           (wr),
		.res          (res)
	);

	assign done          = done_q;
	assign victim_way    = victim_q;
	assign counter_value = cval_q;
	assign count_above   = count_q;
	assign error         = error_q;

	// An accepted request always occupies the sequencer in the next cycle.
	`SHIPRRIP_ASSERT_NXT(a_accept_busy, accept, state_q == ST_SCAN, "request not taken up")
	// Results never arrive in two consecutive cycles.
	`SHIPRRIP_ASSERT_NXT(a_done_single, done_q, !done_q, "result strobe held")
	// The walk pointer never runs past the end of its range.
	`SHIPRRIP_ASSERT_IMP(a_ptr_range, state_q == ST_SCAN, ptr_q <= end_q, "walk overran range")
	// The owed age never exceeds the value that means none.
	`SHIPRRIP_ASSERT_IMP(a_age_bound, 1'b1, pending_age_q <= shiprrip_pkg::AGE_NONE,
		"pending age out of range")
	// A rejected reserved search returns way zero.
	`SHIPRRIP_ASSERT_IMP(a_err_victim, done_q && error_q, victim_q == 4'd0,
		"error result carries a victim")

endmodule
